FILE: hw/rtl/etrq_pkg.sv
// ----------------------------------------------------------------------------
// etrq_pkg
// types, operation codes and default sizes for the entity table query unit
// ----------------------------------------------------------------------------
package etrq_pkg;

  localparam int MAX_ENTRIES_DEF = 32;

  localparam logic [1:0] FN_SPAWN   = 2'd0;
  localparam logic [1:0] FN_DESPAWN = 2'd1;
  localparam logic [1:0] FN_QUERY   = 2'd2;
  localparam logic [1:0] FN_GET     = 2'd3;

  typedef struct packed {
    logic [31:0]        id;
    logic [7:0]         etype;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
  } entry_t;

endpackage

FILE: hw/rtl/etrq_cell.sv
// ----------------------------------------------------------------------------
// etrq_cell
// one table slot of the rotating entry ring
// ----------------------------------------------------------------------------
module etrq_cell import etrq_pkg::*; (
  input  logic   clk,
  input  logic   shift_en,
  input  entry_t nb_i,
  input  logic   wr_en,
  input  entry_t wr_data,
  output entry_t entry_o
);

  entry_t entry_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      entry_r <= wr_data;
    end else if (shift_en) begin
      entry_r <= nb_i;
    end
  end

  assign entry_o = entry_r;

endmodule

FILE: hw/rtl/etrq_dist.sv
// ----------------------------------------------------------------------------
// etrq_dist
// three-stage squared distance pipeline
// ----------------------------------------------------------------------------
module etrq_dist import etrq_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               adv,
  input  logic               vld_i,
  input  logic [31:0]        id_i,
  input  logic signed [15:0] px_i,
  input  logic signed [15:0] py_i,
  input  logic signed [15:0] pz_i,
  input  logic signed [15:0] cx_i,
  input  logic signed [15:0] cy_i,
  input  logic signed [15:0] cz_i,
  output logic               vld_o,
  output logic [31:0]        id_o,
  output logic [33:0]        d2_o
);

  logic               v1_r, v2_r, v3_r;
  logic [31:0]        id1_r, id2_r, id3_r;
  logic signed [16:0] dx_r, dy_r, dz_r;
  logic [31:0]        sx_r, sy_r, sz_r;
  logic [33:0]        d2_r;
  logic [15:0]        ax, ay, az;

  assign ax = dx_r[16] ? 16'(-dx_r) : dx_r[15:0];
  assign ay = dy_r[16] ? 16'(-dy_r) : dy_r[15:0];
  assign az = dz_r[16] ? 16'(-dz_r) : dz_r[15:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (adv) begin
      v1_r <= vld_i;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      id1_r <= id_i;
      dx_r  <= 17'(px_i) - 17'(cx_i);
      dy_r  <= 17'(py_i) - 17'(cy_i);
      dz_r  <= 17'(pz_i) - 17'(cz_i);
      id2_r <= id1_r;
      sx_r  <= ax * ax;
      sy_r  <= ay * ay;
      sz_r  <= az * az;
      id3_r <= id2_r;
      d2_r  <= 34'(sx_r) + 34'(sy_r) + 34'(sz_r);
    end
  end

  assign vld_o = v3_r;
  assign id_o  = id3_r;
  assign d2_o  = d2_r;

endmodule

FILE: hw/rtl/entity_table_radius_query_unit.sv
// ----------------------------------------------------------------------------
// entity_table_radius_query_unit
// packed entity table with spawn, despawn, get and fixed-radius query
// ----------------------------------------------------------------------------
// The table is a ring of MAX_ENTRIES cells that rotates one slot per cycle
// past a single head while the result side is not stalled. Despawn, get and
// query each walk the whole ring once and drain a three-stage distance
// pipeline, and a held result beat stalls the walk; a query emits one beat
// per match, up to in_max_count, and a final count beat.
module entity_table_radius_query_unit import etrq_pkg::*; #(
  parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_func,
  input  logic signed [15:0] in_pos_x,
  input  logic signed [15:0] in_pos_y,
  input  logic signed [15:0] in_pos_z,
  input  logic [7:0]         in_entity_type,
  input  logic [31:0]        in_entity_id,
  input  logic [15:0]        in_radius,
  input  logic [5:0]         in_max_count,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [31:0]        out_result_id,
  output logic [7:0]         out_result_type,
  output logic signed [15:0] out_result_x,
  output logic signed [15:0] out_result_y,
  output logic signed [15:0] out_result_z,
  output logic               out_found,
  output logic [5:0]         out_match_count,
  output logic               out_last
);

  localparam int UW = $clog2(MAX_ENTRIES + 1);
  localparam int CW = $clog2(MAX_ENTRIES + 4);
  localparam logic [CW-1:0] WALK_END = CW'(MAX_ENTRIES + 3);
  localparam logic [CW-1:0] RING_LEN = CW'(MAX_ENTRIES);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_WALK = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;

  logic [1:0]         state_r;
  logic [CW-1:0]      cnt_r;
  logic [UW-1:0]      used_r;
  logic [UW-1:0]      k_r;
  logic [31:0]        next_id_r;
  logic [1:0]         func_r;
  logic [31:0]        req_id_r;
  logic signed [15:0] cx_r, cy_r, cz_r;
  logic [31:0]        r2_r;
  logic [5:0]         limit_r;
  logic [5:0]         n_r;
  logic               hit_r;
  entry_t             hit_e_r;
  entry_t             last_e_r;
  logic [31:0]        res_id_r;

  logic               out_valid_r;
  logic [31:0]        o_id_r;
  logic [7:0]         o_type_r;
  logic signed [15:0] o_x_r, o_y_r, o_z_r;
  logic               o_found_r;
  logic [5:0]         o_cnt_r;
  logic               o_last_r;

  entry_t             ring [MAX_ENTRIES];
  entry_t             head;
  entry_t             spawn_e;
  logic               adv, rot, head_vld, spawn_we, del_we;
  logic               pv;
  logic [31:0]        pid;
  logic [33:0]        pd2;
  logic               pmatch;
  logic               o_load;

  assign adv      = !out_valid_r || out_ready;
  assign head     = ring[0];
  assign rot      = (state_r == S_WALK) && adv && (cnt_r < RING_LEN);
  assign head_vld = rot && (cnt_r < CW'(used_r));
  assign spawn_we = in_valid && in_ready && (in_func == FN_SPAWN)
                    && (used_r < UW'(MAX_ENTRIES));
  assign del_we   = (state_r == S_WALK) && (cnt_r == WALK_END)
                    && (func_r == FN_DESPAWN) && hit_r;
  assign spawn_e  = '{id: next_id_r, etype: in_entity_type,
                      x: in_pos_x, y: in_pos_y, z: in_pos_z};
  assign pmatch   = pv && (pd2 <= 34'(r2_r)) && (n_r < limit_r);
  assign o_load   = adv && (((state_r == S_WALK) && (cnt_r != WALK_END) && pmatch)
                            || (state_r == S_FIN));

  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_ring
    localparam int NB = (i + 1) % MAX_ENTRIES;
    logic   wr_en;
    entry_t wr_data;
    assign wr_en   = (spawn_we && used_r == UW'(i)) || (del_we && k_r == UW'(i));
    assign wr_data = spawn_we ? spawn_e : last_e_r;
    etrq_cell u_cell (
      .clk     (clk),
      .shift_en(rot),
      .nb_i    (ring[NB]),
      .wr_en   (wr_en),
      .wr_data (wr_data),
      .entry_o (ring[i])
    );
  end

  etrq_dist u_dist (
    .clk  (clk),
    .rst_n(rst_n),
    .adv  (adv),
    .vld_i(head_vld && (func_r == FN_QUERY)),
    .id_i (head.id),
    .px_i (head.x),
    .py_i (head.y),
    .pz_i (head.z),
    .cx_i (cx_r),
    .cy_i (cy_r),
    .cz_i (cz_r),
    .vld_o(pv),
    .id_o (pid),
    .d2_o (pd2)
  );

  assign in_ready = (state_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      used_r      <= '0;
      next_id_r   <= 32'd1;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
      hit_r       <= 1'b0;
      n_r         <= '0;
    end else begin
      if (o_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            func_r   <= in_func;
            req_id_r <= in_entity_id;
            cx_r     <= in_pos_x;
            cy_r     <= in_pos_y;
            cz_r     <= in_pos_z;
            r2_r     <= in_radius * in_radius;
            limit_r  <= in_max_count;
            cnt_r    <= '0;
            n_r      <= '0;
            hit_r    <= 1'b0;
            hit_e_r  <= '0;
            if (in_func == FN_SPAWN) begin
              state_r <= S_FIN;
              if (spawn_we) begin
                res_id_r  <= next_id_r;
                next_id_r <= next_id_r + 32'd1;
                used_r    <= used_r + UW'(1);
              end else begin
                res_id_r <= '0;
              end
            end else begin
              state_r <= S_WALK;
            end
          end
        end
        S_WALK: begin
          if (cnt_r == WALK_END) begin
            state_r <= S_FIN;
            if (del_we) begin
              used_r <= used_r - UW'(1);
            end
          end else if (adv) begin
            cnt_r <= cnt_r + CW'(1);
            if (head_vld && head.id == req_id_r && !hit_r) begin
              hit_r   <= 1'b1;
              k_r     <= UW'(cnt_r);
              hit_e_r <= head;
            end
            if (head_vld && cnt_r == CW'(used_r) - CW'(1)) begin
              last_e_r <= head;
            end
            if (pmatch) begin
              n_r         <= n_r + 6'd1;
              o_id_r      <= pid;
              o_type_r    <= '0;
              o_x_r       <= '0;
              o_y_r       <= '0;
              o_z_r       <= '0;
              o_found_r   <= 1'b0;
              o_cnt_r     <= '0;
              o_last_r    <= 1'b0;
            end
          end
        end
        S_FIN: begin
          if (adv) begin
            state_r     <= S_IDLE;
            o_id_r      <= (func_r == FN_SPAWN) ? res_id_r : '0;
            o_type_r    <= (func_r == FN_GET) ? hit_e_r.etype : '0;
            o_x_r       <= (func_r == FN_GET) ? hit_e_r.x : '0;
            o_y_r       <= (func_r == FN_GET) ? hit_e_r.y : '0;
            o_z_r       <= (func_r == FN_GET) ? hit_e_r.z : '0;
            o_found_r   <= (func_r == FN_GET || func_r == FN_DESPAWN) && hit_r;
            o_cnt_r     <= (func_r == FN_QUERY) ? n_r : '0;
            o_last_r    <= 1'b1;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid       = out_valid_r;
  assign out_result_id   = o_id_r;
  assign out_result_type = o_type_r;
  assign out_result_x    = o_x_r;
  assign out_result_y    = o_y_r;
  assign out_result_z    = o_z_r;
  assign out_found       = o_found_r;
  assign out_match_count = o_cnt_r;
  assign out_last        = o_last_r;

endmodule

FILE: sim/entity_table_radius_query_unit_tb.sv
// ----------------------------------------------------------------------------
// entity_table_radius_query_unit_tb
// checks spawn, despawn, get and radius query against an in-bench table model
// with random bursts on the input side and random stalls on the result side
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module entity_table_radius_query_unit_tb;
  import etrq_pkg::*;

  localparam int DEPTH = MAX_ENTRIES_DEF;

  typedef struct packed {
    logic [31:0]        id;
    logic [7:0]         etype;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
    logic               found;
    logic [5:0]         count;
    logic               last;
  } beat_t;

  class table_scoreboard;
    entry_t      slots[DEPTH];
    int          used;
    logic [31:0] next_id;
    beat_t       pending[$];
    int          errors;
    int          n_beats;

    function new();
      used = 0;
      next_id = 32'd1;
      errors = 0;
      n_beats = 0;
    endfunction

    function int find_id(logic [31:0] id);
      for (int i = 0; i < used; i++) if (slots[i].id == id) return i;
      return -1;
    endfunction

    function longint sqd(logic signed [15:0] a, logic signed [15:0] b);
      longint d;
      d = longint'(a) - longint'(b);
      return d * d;
    endfunction

    function void note_input(logic [1:0] fn, entry_t e, logic [15:0] r, logic [5:0] mc);
      beat_t  b;
      int     k;
      int     n;
      longint r2;
      b = '0;
      b.last = 1'b1;
      case (fn)
        FN_SPAWN: begin
          if (used < DEPTH) begin
            e.id = next_id;
            slots[used] = e;
            used++;
            b.id = next_id;
            next_id++;
          end
          pending.push_back(b);
        end
        FN_DESPAWN: begin
          k = find_id(e.id);
          if (k >= 0) begin
            slots[k] = slots[used-1];
            used--;
            b.found = 1'b1;
          end
          pending.push_back(b);
        end
        FN_GET: begin
          k = find_id(e.id);
          if (k >= 0) begin
            b.found = 1'b1;
            b.etype = slots[k].etype;
            b.x = slots[k].x;
            b.y = slots[k].y;
            b.z = slots[k].z;
          end
          pending.push_back(b);
        end
        default: begin
          r2 = longint'(r) * longint'(r);
          n = 0;
          for (int i = 0; i < used && n < mc; i++) begin
            if (sqd(slots[i].x, e.x) + sqd(slots[i].y, e.y) + sqd(slots[i].z, e.z) <= r2) begin
              beat_t m;
              m = '0;
              m.id = slots[i].id;
              pending.push_back(m);
              n++;
            end
          end
          b.count = 6'(n);
          pending.push_back(b);
        end
      endcase
    endfunction

    function void check_beat(beat_t act);
      beat_t exp;
      n_beats++;
      if (pending.size() == 0) begin
        $error("result beat with nothing expected, id %0h", act.id);
        errors++;
        return;
      end
      exp = pending.pop_front();
      if (act.id !== exp.id) begin
        $error("result_id exp %0h act %0h", exp.id, act.id); errors++;
      end
      if (act.etype !== exp.etype) begin
        $error("result_type exp %0h act %0h", exp.etype, act.etype); errors++;
      end
      if (act.x !== exp.x) begin
        $error("result_x exp %0d act %0d", exp.x, act.x); errors++;
      end
      if (act.y !== exp.y) begin
        $error("result_y exp %0d act %0d", exp.y, act.y); errors++;
      end
      if (act.z !== exp.z) begin
        $error("result_z exp %0d act %0d", exp.z, act.z); errors++;
      end
      if (act.found !== exp.found) begin
        $error("found exp %0b act %0b", exp.found, act.found); errors++;
      end
      if (act.count !== exp.count) begin
        $error("match_count exp %0d act %0d", exp.count, act.count); errors++;
      end
      if (act.last !== exp.last) begin
        $error("last exp %0b act %0b", exp.last, act.last); errors++;
      end
    endfunction
  endclass

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic [1:0]         in_func;
  logic signed [15:0] in_pos_x;
  logic signed [15:0] in_pos_y;
  logic signed [15:0] in_pos_z;
  logic [7:0]         in_entity_type;
  logic [31:0]        in_entity_id;
  logic [15:0]        in_radius;
  logic [5:0]         in_max_count;
  logic               out_valid;
  logic               out_ready;
  logic [31:0]        out_result_id;
  logic [7:0]         out_result_type;
  logic signed [15:0] out_result_x;
  logic signed [15:0] out_result_y;
  logic signed [15:0] out_result_z;
  logic               out_found;
  logic [5:0]         out_match_count;
  logic               out_last;

  table_scoreboard sb;
  int  n_items;
  int  n_queries;
  bit  long_hold;

  entity_table_radius_query_unit i_dut (.*);

  always begin
    clk = 1'b1; #6;
    clk = 1'b0; #6;
  end

  // result side: stall pattern, plus one long hold-off
  initial begin
    int mode;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold) begin
        out_ready <= 1'b0;
        repeat (300) @(posedge clk);
        long_hold = 1'b0;
      end
      mode = (n_items / 60) % 3;
      if (mode == 0) out_ready <= 1'b1;
      else if (mode == 1) out_ready <= ($urandom_range(0, 3) != 0);
      else out_ready <= ($urandom_range(0, 1) != 0);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_beat('{out_result_id, out_result_type, out_result_x, out_result_y,
                      out_result_z, out_found, out_match_count, out_last});
  end

  task automatic send(logic [1:0] fn, logic signed [15:0] x, logic signed [15:0] y,
                      logic signed [15:0] z, logic [7:0] t, logic [31:0] id,
                      logic [15:0] r, logic [5:0] mc);
    entry_t e;
    in_valid       <= 1'b1;
    in_func        <= fn;
    in_pos_x       <= x;
    in_pos_y       <= y;
    in_pos_z       <= z;
    in_entity_type <= t;
    in_entity_id   <= id;
    in_radius      <= r;
    in_max_count   <= mc;
    do @(posedge clk); while (!in_ready);
    e = '{id, t, x, y, z};
    sb.note_input(fn, e, r, mc);
    n_items++;
    if (fn == FN_QUERY) n_queries++;
  endtask

  task automatic idle(int n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_id();
    if (sb.used > 0 && $urandom_range(0, 4) != 0)
      return sb.slots[$urandom_range(0, sb.used - 1)].id;
    if ($urandom_range(0, 1)) return sb.next_id + 32'($urandom_range(0, 3));
    return $urandom;
  endfunction

  task automatic rand_item();
    int          sel;
    logic [1:0]  fn;
    logic [15:0] cx, cy, cz;
    sel = $urandom_range(0, 99);
    if (sb.used < 6) fn = (sel < 70) ? FN_SPAWN : logic'(sel[0]) ? FN_QUERY : FN_GET;
    else if (sel < 30) fn = FN_SPAWN;
    else if (sel < 45) fn = FN_DESPAWN;
    else if (sel < 75) fn = FN_QUERY;
    else fn = FN_GET;
    if ($urandom_range(0, 3) == 0) begin
      cx = 16'($urandom); cy = 16'($urandom); cz = 16'($urandom);
    end else begin
      cx = 16'($signed($urandom_range(0, 2047)) - 1024);
      cy = 16'($signed($urandom_range(0, 2047)) - 1024);
      cz = 16'($signed($urandom_range(0, 2047)) - 1024);
    end
    send(fn, cx, cy, cz, 8'($urandom), pick_id(),
         ($urandom_range(0, 5) == 0) ? 16'($urandom) : 16'($urandom_range(0, 1500)),
         6'($urandom_range(0, 33)));
  endtask

  initial begin
    int gap;
    sb = new();
    n_items = 0;
    n_queries = 0;
    long_hold = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_func = FN_SPAWN;
    in_pos_x = '0;
    in_pos_y = '0;
    in_pos_z = '0;
    in_entity_type = '0;
    in_entity_id = '0;
    in_radius = '0;
    in_max_count = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty table, extremes, all operations
    send(FN_QUERY, 0, 0, 0, 0, 0, 16'hffff, 6'd32);
    send(FN_GET, 0, 0, 0, 0, 32'd1, 0, 0);
    send(FN_DESPAWN, 0, 0, 0, 0, 32'd1, 0, 0);
    send(FN_SPAWN, 16'sh7fff, 16'sh7fff, 16'sh7fff, 8'hff, 0, 0, 0);
    send(FN_SPAWN, -16'sh8000, -16'sh8000, -16'sh8000, 8'h00, 32'hffffffff, 16'hffff, 6'h3f);
    send(FN_SPAWN, 0, 0, 0, 8'h5a, 0, 0, 0);
    send(FN_GET, 0, 0, 0, 0, 32'd1, 0, 0);
    send(FN_GET, 0, 0, 0, 0, 32'd2, 0, 0);
    send(FN_QUERY, -16'sh8000, -16'sh8000, -16'sh8000, 0, 0, 16'hffff, 6'd32);
    send(FN_QUERY, 16'sh7fff, 16'sh7fff, 16'sh7fff, 0, 0, 16'hffff, 6'd63);
    send(FN_QUERY, 0, 0, 0, 0, 0, 16'hffff, 6'd0);
    send(FN_QUERY, 0, 0, 0, 0, 0, 16'd0, 6'd1);
    send(FN_DESPAWN, 0, 0, 0, 0, 32'd1, 0, 0);
    send(FN_GET, 0, 0, 0, 0, 32'd3, 0, 0);
    send(FN_GET, 0, 0, 0, 0, 32'd1, 0, 0);
    // fill past capacity, then query everything
    while (sb.used < DEPTH) send(FN_SPAWN, 16'($urandom), 16'($urandom), 16'($urandom),
                                 8'($urandom), 0, 0, 0);
    send(FN_SPAWN, 1, 2, 3, 8'h11, 0, 0, 0);
    send(FN_QUERY, 0, 0, 0, 0, 0, 16'hffff, 6'd32);
    drain();

    // long hold-off on the result side while the sender keeps offering
    long_hold = 1'b1;
    for (int i = 0; i < 12; i++) rand_item();
    drain();

    while (n_items < 480) begin
      for (int b = $urandom_range(1, 12); b > 0; b--) rand_item();
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) idle(gap);
      if ($urandom_range(0, 30) == 0) drain();
    end
    drain();
    repeat (60) @(posedge clk);

    $display("ran %0d items (%0d queries), checked %0d result beats",
             n_items, n_queries, sb.n_beats);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("entity_table_radius_query_unit verification clean");
    else
      $display("entity_table_radius_query_unit verification failed");
    $finish;
  end

  initial begin
    #20ms;
    $display("entity_table_radius_query_unit verification failed");
    $finish;
  end

endmodule
